// ----- rtl/core/hmlpd_pkg.sv -----
// Shared types, constants and helpers for the heatmap local peak detector.
// Used by heatmap_local_peak_detect_unit; no dependencies of its own.

package hmlpd_pkg;

  // Grid geometry
  localparam int MAX_GRID     = 63;
  localparam int MAX_OUT      = 64;  // decisions one pixel may release at most
  localparam int GRID_USE_MAX = (MAX_GRID < MAX_OUT - 2) ? MAX_GRID : MAX_OUT - 2;
  localparam int GRID_USE_MIN = 2;

  // Field widths
  localparam int SCORE_W   = 16;
  localparam int POS_W     = $clog2(MAX_GRID + 1);
  localparam int CH_W      = 5;
  localparam int REG_IDX_W = 8;
  localparam int CFG_W     = 16;
  localparam int LINE_W    = 2 * SCORE_W;   // {older row, newer row} per column

  // Output stream packing: row, col, score, peak, then zero fill to bytes
  localparam int OUT_FIELDS_W = 2 * POS_W + SCORE_W + 1;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  // Result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [FIFO_CW-1:0] FIFO_FULL      = FIFO_CW'(FIFO_DEPTH);
  // Occupancy that still leaves room for the item in flight and a new one
  localparam logic [FIFO_CW-1:0] FIFO_LIM_BUSY  = FIFO_CW'(FIFO_DEPTH - 4);
  localparam logic [FIFO_CW-1:0] FIFO_LIM_EMPTY = FIFO_CW'(FIFO_DEPTH - 2);

  // Size limits as position codes
  localparam logic [POS_W-1:0] GRID_MAX_C = POS_W'(GRID_USE_MAX);
  localparam logic [POS_W-1:0] GRID_MIN_C = POS_W'(GRID_USE_MIN);

  // Register map
  localparam logic [REG_IDX_W-1:0] REG_SCORE_THRESHOLD = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_GRID_SIZE       = REG_IDX_W'(1);

  // Reset values: threshold 0.5 in Q0.16, grid of 33
  localparam logic [SCORE_W-1:0] THRESHOLD_RST = SCORE_W'(32768);
  localparam logic [POS_W-1:0]   GRID_SIZE_RST = POS_W'(33);

  typedef enum logic {
    ST_RUN,
    ST_FLUSH
  } hmlpd_state_e;

  typedef struct packed {
    logic [CH_W-1:0]    out_channel;
    logic [POS_W-1:0]   pixel_row;
    logic [POS_W-1:0]   pixel_col;
    logic [SCORE_W-1:0] kept_score;
    logic               is_peak;
    logic               frame_last;
  } hmlpd_result_t;

  function automatic logic [SCORE_W-1:0] max_score(input logic [SCORE_W-1:0] a,
                                                   input logic [SCORE_W-1:0] b);
    max_score = (a > b) ? a : b;
  endfunction

  // Nonzero center that matches the window maximum; ties count
  function automatic logic peak_of(input logic [SCORE_W-1:0] center,
                                   input logic [SCORE_W-1:0] wmax);
    peak_of = (center != '0) && (center == wmax);
  endfunction

endpackage

// ----- rtl/core/hmlpd_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.

module hmlpd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/heatmap_local_peak_detect_unit.sv -----
// Top level of the heatmap 3x3 local peak detector.
// Depends on hmlpd_pkg and hmlpd_ram.

// One heatmap score enters per clock in raster order, column fastest, if the
// queue has room; each pixel is decided once its 3x3 neighborhood is in, one row
// and one column behind the input, and results leave through an 8-entry queue at
// one per clock when not stalled. The two line stores sit in one RAM word per
// column, read the cycle a sample is taken and written back the next. At the
// last pixel of a grid of size g the input is held off while the last row's g
// decisions are swept out, one column per cycle unless the queue is full;
// frame_last marks the last one. The channel comes from each grid's first pixel.

module heatmap_local_peak_detect_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Sample stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [hmlpd_pkg::SCORE_W-1:0]       s_axis_tdata,   // [15:0] sample_score
  input  logic [hmlpd_pkg::CH_W-1:0]          s_axis_tuser,   // [4:0] channel_id
  // Decision stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [5:0] pixel_row, [11:6] pixel_col, [27:12] kept_score, [28] is_peak, rest zero
  output logic [hmlpd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic [hmlpd_pkg::CH_W-1:0]          m_axis_tuser,   // [4:0] out_channel
  output logic                                m_axis_tlast,   // frame_last
  // Register writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [hmlpd_pkg::REG_IDX_W-1:0]     cfg_index_i,
  input  logic [hmlpd_pkg::CFG_W-1:0]         cfg_wdata_i
);

  localparam int SW = hmlpd_pkg::SCORE_W;
  localparam int PW = hmlpd_pkg::POS_W;

  // Configuration
  logic [SW-1:0] thr_q;
  logic [PW-1:0] gs_q;
  logic [PW-1:0] g;
  logic [PW-1:0] g_m1;

  // Input position tracking
  logic          in_acc;
  logic          wrap;
  logic [PW-1:0] in_row_q, in_row_d;
  logic [PW-1:0] in_col_q, in_col_d;
  logic [PW-1:0] acc_row, acc_col;
  logic [hmlpd_pkg::CH_W-1:0] held_q;
  logic [SW-1:0] acc_kept;

  // Processing stage
  logic          p_valid_q;
  logic [PW-1:0] p_row_q, p_col_q;
  logic [SW-1:0] p_kept_q;
  logic          r_ge1, r_ge2, c_first, c_last, r_last, p_lastpix;
  logic [SW-1:0] win_q [2][3];
  logic [SW-1:0] wa [3];
  logic [SW-1:0] wb [3];
  logic [SW-1:0] wc [3];
  logic [SW-1:0] max1, max2;
  logic          emit1, emit2;
  hmlpd_pkg::hmlpd_result_t d1, d2;

  // Line store RAM
  logic                        ram_we, ram_re;
  logic [PW-1:0]               ram_waddr, ram_raddr;
  logic [hmlpd_pkg::LINE_W-1:0] ram_wdata, ram_rdata;
  logic [SW-1:0]               rd_older, rd_newer;

  // Last-row sweep
  hmlpd_pkg::hmlpd_state_e st_q, st_d;
  logic [PW-1:0] fcol_q;
  logic [PW-1:0] fcol_p1;
  logic [SW-1:0] fw_q [2][2];
  logic [SW-1:0] fc [2];
  logic [SW-1:0] fmax;
  logic          fl_step, femit;
  hmlpd_pkg::hmlpd_result_t fd;

  // Result queue
  hmlpd_pkg::hmlpd_result_t fifo_q [hmlpd_pkg::FIFO_DEPTH];
  hmlpd_pkg::hmlpd_result_t e0, e1, head;
  logic [hmlpd_pkg::FIFO_AW-1:0] wp_q, rp_q, wp1;
  logic [hmlpd_pkg::FIFO_CW-1:0] cnt_q, room_lim;
  logic [1:0]                    push_n;
  logic                          pop;

  // ---------------------------------------------------------------------------
  // Configuration port, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= hmlpd_pkg::THRESHOLD_RST;
      gs_q  <= hmlpd_pkg::GRID_SIZE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        hmlpd_pkg::REG_SCORE_THRESHOLD: thr_q <= cfg_wdata_i[SW-1:0];
        hmlpd_pkg::REG_GRID_SIZE:       gs_q  <= cfg_wdata_i[PW-1:0];
        default: ;
      endcase
    end
  end

  // Grid size in use, clamped
  always_comb begin
    if (gs_q > hmlpd_pkg::GRID_MAX_C) begin
      g = hmlpd_pkg::GRID_MAX_C;
    end else if (gs_q < hmlpd_pkg::GRID_MIN_C) begin
      g = hmlpd_pkg::GRID_MIN_C;
    end else begin
      g = gs_q;
    end
  end
  assign g_m1 = g - PW'(1);

  // ---------------------------------------------------------------------------
  // Input side: position, threshold, line store read
  assign p_lastpix = p_valid_q && r_last && c_last;
  assign room_lim  = p_valid_q ? hmlpd_pkg::FIFO_LIM_BUSY : hmlpd_pkg::FIFO_LIM_EMPTY;
  assign s_axis_tready = (st_q == hmlpd_pkg::ST_RUN) && !p_lastpix && (cnt_q <= room_lim);
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // An out-of-range position restarts the grid
  assign wrap     = (in_row_q >= g) || (in_col_q >= g);
  assign acc_row  = wrap ? '0 : in_row_q;
  assign acc_col  = wrap ? '0 : in_col_q;
  assign acc_kept = (s_axis_tdata < thr_q) ? '0 : s_axis_tdata;

  always_comb begin
    if (acc_col == g_m1) begin
      in_col_d = '0;
      in_row_d = (acc_row == g_m1) ? '0 : acc_row + PW'(1);
    end else begin
      in_col_d = acc_col + PW'(1);
      in_row_d = acc_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q  <= '0;
      in_col_q  <= '0;
      held_q    <= '0;
      p_valid_q <= 1'b0;
    end else begin
      p_valid_q <= in_acc;
      if (in_acc) begin
        in_row_q <= in_row_d;
        in_col_q <= in_col_d;
        if ((acc_row == '0) && (acc_col == '0)) begin
          held_q <= s_axis_tuser;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      p_row_q  <= acc_row;
      p_col_q  <= acc_col;
      p_kept_q <= acc_kept;
    end
  end

  // ---------------------------------------------------------------------------
  // Processing stage: window shift and up to two decisions
  assign rd_older = ram_rdata[hmlpd_pkg::LINE_W-1:SW];
  assign rd_newer = ram_rdata[SW-1:0];

  assign r_ge1   = (p_row_q != '0);
  assign r_ge2   = (p_row_q >= PW'(2));
  assign c_first = (p_col_q == '0);
  assign c_last  = (p_col_q == g_m1);
  assign r_last  = (p_row_q == g_m1);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wa[i] = c_first ? '0 : win_q[0][i];
      wb[i] = c_first ? '0 : win_q[1][i];
    end
    wc[0] = r_ge2 ? rd_older : '0;
    wc[1] = r_ge1 ? rd_newer : '0;
    wc[2] = p_kept_q;
    // full window around the left-behind pixel, and the edge window at row end
    max2 = '0;
    for (int i = 0; i < 3; i++) begin
      max2 = hmlpd_pkg::max_score(max2, hmlpd_pkg::max_score(wb[i], wc[i]));
    end
    max1 = hmlpd_pkg::max_score(max2,
             hmlpd_pkg::max_score(wa[0], hmlpd_pkg::max_score(wa[1], wa[2])));
  end

  assign emit1 = p_valid_q && r_ge1 && !c_first;
  assign emit2 = p_valid_q && r_ge1 && c_last;

  always_comb begin
    d1.out_channel = held_q;
    d1.pixel_row   = p_row_q - PW'(1);
    d1.pixel_col   = p_col_q - PW'(1);
    d1.kept_score  = wb[1];
    d1.is_peak     = hmlpd_pkg::peak_of(wb[1], max1);
    d1.frame_last  = 1'b0;
    d2.out_channel = held_q;
    d2.pixel_row   = p_row_q - PW'(1);
    d2.pixel_col   = p_col_q;
    d2.kept_score  = wc[1];
    d2.is_peak     = hmlpd_pkg::peak_of(wc[1], max2);
    d2.frame_last  = 1'b0;
  end

  // Window keeps the two newest columns
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        win_q[0][i] <= '0;
        win_q[1][i] <= '0;
      end
    end else if (p_valid_q) begin
      for (int i = 0; i < 3; i++) begin
        win_q[0][i] <= wb[i];
        win_q[1][i] <= wc[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Line store: newer row moves to older, kept score becomes newer
  assign ram_we    = p_valid_q;
  assign ram_waddr = p_col_q;
  assign ram_wdata = {rd_newer, p_kept_q};
  assign fcol_p1   = fcol_q + PW'(1);

  always_comb begin
    if (p_lastpix) begin
      ram_re    = 1'b1;
      ram_raddr = '0;
    end else if (fl_step) begin
      ram_re    = (fcol_p1 < g);
      ram_raddr = fcol_p1;
    end else begin
      ram_re    = in_acc;
      ram_raddr = acc_col;
    end
  end

  hmlpd_ram #(
    .WIDTH (hmlpd_pkg::LINE_W),
    .DEPTH (hmlpd_pkg::MAX_GRID)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Last-row sweep: one column per step, decision for the column before it
  always_comb begin
    st_d    = st_q;
    fl_step = 1'b0;
    case (st_q)
      hmlpd_pkg::ST_RUN: begin
        if (p_lastpix) begin
          st_d = hmlpd_pkg::ST_FLUSH;
        end
      end
      hmlpd_pkg::ST_FLUSH: begin
        fl_step = (cnt_q != hmlpd_pkg::FIFO_FULL);
        if (fl_step && (fcol_q == g)) begin
          st_d = hmlpd_pkg::ST_RUN;
        end
      end
      default: st_d = hmlpd_pkg::ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= hmlpd_pkg::ST_RUN;
    end else begin
      st_q <= st_d;
    end
  end

  // Column past the right edge reads as zero; bottom row is always zero
  assign fc[0] = (fcol_q < g) ? rd_older : '0;
  assign fc[1] = (fcol_q < g) ? rd_newer : '0;
  assign fmax  = hmlpd_pkg::max_score(
                   hmlpd_pkg::max_score(hmlpd_pkg::max_score(fw_q[0][0], fw_q[0][1]),
                                        hmlpd_pkg::max_score(fw_q[1][0], fw_q[1][1])),
                   hmlpd_pkg::max_score(fc[0], fc[1]));
  assign femit = fl_step && (fcol_q != '0);

  always_comb begin
    fd.out_channel = held_q;
    fd.pixel_row   = g_m1;
    fd.pixel_col   = fcol_q - PW'(1);
    fd.kept_score  = fw_q[1][1];
    fd.is_peak     = hmlpd_pkg::peak_of(fw_q[1][1], fmax);
    fd.frame_last  = (fcol_q == g);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcol_q <= '0;
      for (int i = 0; i < 2; i++) begin
        fw_q[0][i] <= '0;
        fw_q[1][i] <= '0;
      end
    end else if (p_lastpix) begin
      fcol_q <= '0;
      for (int i = 0; i < 2; i++) begin
        fw_q[0][i] <= '0;
        fw_q[1][i] <= '0;
      end
    end else if (fl_step) begin
      fcol_q <= fcol_p1;
      for (int i = 0; i < 2; i++) begin
        fw_q[0][i] <= fw_q[1][i];
        fw_q[1][i] <= fc[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result queue: up to two pushes, one pop per cycle
  always_comb begin
    if (p_valid_q) begin
      e0     = d1;
      e1     = d2;
      push_n = emit1 ? (emit2 ? 2'd2 : 2'd1) : 2'd0;
    end else begin
      e0     = fd;
      e1     = fd;
      push_n = femit ? 2'd1 : 2'd0;
    end
  end

  assign wp1  = wp_q + hmlpd_pkg::FIFO_AW'(1);
  assign head = fifo_q[rp_q];
  assign pop  = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < hmlpd_pkg::FIFO_DEPTH; i++) begin
      if ((push_n != 2'd0) && (hmlpd_pkg::FIFO_AW'(i) == wp_q)) begin
        fifo_q[i] <= e0;
      end else if ((push_n == 2'd2) && (hmlpd_pkg::FIFO_AW'(i) == wp1)) begin
        fifo_q[i] <= e1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + hmlpd_pkg::FIFO_AW'(push_n);
      rp_q  <= rp_q + hmlpd_pkg::FIFO_AW'(pop);
      cnt_q <= cnt_q + hmlpd_pkg::FIFO_CW'(push_n) - hmlpd_pkg::FIFO_CW'(pop);
    end
  end

  // Output transaction from the queue head
  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = {{hmlpd_pkg::OUT_PAD_W{1'b0}}, head.is_peak, head.kept_score,
                          head.pixel_col, head.pixel_row};
  assign m_axis_tuser  = head.out_channel;
  assign m_axis_tlast  = head.frame_last;

endmodule
